[sv/lir_pkg.sv]
// Shared types and constants of the linear interpolating resampler.
package lir_pkg;

    // Sample and phase widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned PHASE_W  = 21;

    // Q.16 fixed-point constants for phase and step.
    localparam logic [PHASE_W-1:0] ONE_Q16    = 21'd65536;
    localparam logic [PHASE_W-1:0] STEP_MIN   = 21'd1024;
    localparam logic [PHASE_W-1:0] STEP_MAX   = 21'd1048576;
    localparam logic [PHASE_W-1:0] STEP_RESET = 21'd98304;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_HOLD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;   // latch the incoming sample
        logic mul;       // register the interpolation product
        logic load;      // fill the output register and advance the phase
        logic finish;    // drop the phase by one and keep the sample as previous
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic phase_ge_one;  // phase has reached 1.0
        logic out_busy;      // output register holds a request
        logic out_taken;     // output request accepted in this cycle
    } t_sts;

endpackage

[sv/linear_interpolating_resampler.sv]
// Top level of the linear interpolating resampler: controller and datapath.
// Each input sample yields from none to 64 output samples on a fractional Q.16 phase; the last
// output of each input carries o_last_of_run. For each output the block registers the product,
// loads the output register and then presents the request until it is taken; per input it
// also accepts the sample and closes the phase. This is set by the controller walking one
// output at a time through the single multiplier and the one output register, so a new input
// is accepted only once every output of the last one has been taken. The step register takes
// a write in any cycle, so it should only be written while no request is in flight.
module linear_interpolating_resampler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] i_in_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lir_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                                o_last_of_run,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [lir_pkg::PHASE_W-1:0]  i_cfg_data
);

    lir_pkg::t_cmd cmd;
    lir_pkg::t_sts sts;

    // The step register can always take a write.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Arithmetic and state.
    lir_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_in_sample   (i_in_sample),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_sample  (o_out_sample),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[sv/lir_ctrl.sv]
// Controller state machine of the linear interpolating resampler.
module lir_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lir_pkg::t_sts i_sts,
    output lir_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    lir_pkg::t_state r_state;
    lir_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lir_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lir_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lir_pkg::ST_MUL;
                end
            end
            lir_pkg::ST_MUL: begin
                if (i_sts.phase_ge_one) begin
                    n_state = lir_pkg::ST_IDLE;
                end else begin
                    n_state = lir_pkg::ST_LOAD;
                end
            end
            lir_pkg::ST_LOAD: begin
                n_state = lir_pkg::ST_HOLD;
            end
            lir_pkg::ST_HOLD: begin
                if (i_sts.out_taken) begin
                    n_state = lir_pkg::ST_MUL;
                end
            end
            default: begin
                n_state = lir_pkg::ST_IDLE;
            end
        endcase
    end

    // Command decode.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lir_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.take_in = i_in_valid;
            end
            lir_pkg::ST_MUL: begin
                o_cmd.mul    = !i_sts.phase_ge_one;
                o_cmd.finish = i_sts.phase_ge_one;
            end
            lir_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            lir_pkg::ST_HOLD: begin
                o_cmd = '0;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The output register is only full while the controller waits for it to drain.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.out_busy |-> r_state == lir_pkg::ST_HOLD)
        else $error("output request outside the hold state");

    // A load never overwrites a pending output request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && i_sts.out_busy))
        else $error("load while output register busy");

    // Closing an input always returns to idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == lir_pkg::ST_IDLE)
        else $error("finish not followed by idle");

    // A taken input is checked against the phase in the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_in |=> r_state == lir_pkg::ST_MUL)
        else $error("accepted sample not processed");

endmodule

[sv/lir_datapath.sv]
// Datapath of the linear interpolating resampler: phase, samples, product and output register.
module lir_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lir_pkg::t_cmd                       i_cmd,
    output lir_pkg::t_sts                       o_sts,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] i_in_sample,
    input  logic                                i_cfg_valid,
    input  logic        [lir_pkg::PHASE_W-1:0]  i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [lir_pkg::SAMPLE_W-1:0] o_out_sample,
    output logic                                o_last_of_run
);

    localparam logic signed [18:0] SAT_HI = 19'sd32767;
    localparam logic signed [18:0] SAT_LO = -19'sd32768;

    logic        [lir_pkg::PHASE_W-1:0]  r_step;
    logic        [lir_pkg::PHASE_W-1:0]  r_phase;
    logic signed [lir_pkg::SAMPLE_W-1:0] r_prev;
    logic                                r_primed;
    logic signed [lir_pkg::SAMPLE_W-1:0] r_cur;
    logic signed [33:0]                  r_prod;
    logic                                r_out_valid;
    logic signed [lir_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                                r_last;

    logic        [lir_pkg::PHASE_W-1:0]  step_use;
    logic        [lir_pkg::PHASE_W:0]    phase_sum;
    logic signed [16:0]                  diff;
    logic signed [16:0]                  frac;
    logic signed [33:0]                  n_prod;
    logic signed [33:0]                  prod_shr;
    logic signed [18:0]                  interp;
    logic signed [lir_pkg::SAMPLE_W-1:0] n_out_sample;
    logic                                out_taken;

    // Step in use is clamped to the range 1/64 .. 16.0.
    always_comb begin
        if (r_step < lir_pkg::STEP_MIN) begin
            step_use = lir_pkg::STEP_MIN;
        end else if (r_step > lir_pkg::STEP_MAX) begin
            step_use = lir_pkg::STEP_MAX;
        end else begin
            step_use = r_step;
        end
    end

    // Phase advance; the flag for the last output comes from the advanced phase.
    assign phase_sum = {1'b0, r_phase} + {1'b0, step_use};

    // Difference times fractional phase; the phase is below one whenever this is used.
    assign diff   = {r_cur[lir_pkg::SAMPLE_W-1], r_cur} - {r_prev[lir_pkg::SAMPLE_W-1], r_prev};
    assign frac   = {1'b0, r_phase[15:0]};
    assign n_prod = diff * frac;

    // Floor by 2^16, add the previous sample and saturate; before priming, the current sample passes.
    always_comb begin
        prod_shr = r_prod >>> 16;
        interp   = {{3{r_prev[lir_pkg::SAMPLE_W-1]}}, r_prev} + prod_shr[18:0];
        if (!r_primed) begin
            n_out_sample = r_cur;
        end else if (interp > SAT_HI) begin
            n_out_sample = SAT_HI[lir_pkg::SAMPLE_W-1:0];
        end else if (interp < SAT_LO) begin
            n_out_sample = SAT_LO[lir_pkg::SAMPLE_W-1:0];
        end else begin
            n_out_sample = interp[lir_pkg::SAMPLE_W-1:0];
        end
    end

    assign out_taken = r_out_valid && !i_out_stall;

    // Control registers: step, phase, previous sample, primed flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= lir_pkg::STEP_RESET;
            r_phase     <= '0;
            r_prev      <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_phase <= phase_sum[lir_pkg::PHASE_W-1:0];
            end else if (i_cmd.finish) begin
                r_phase <= r_phase - lir_pkg::ONE_Q16;
            end
            if (i_cmd.finish) begin
                r_prev   <= r_cur;
                r_primed <= 1'b1;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_cur <= i_in_sample;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.load) begin
            r_out_sample <= n_out_sample;
            r_last       <= (phase_sum >= {1'b0, lir_pkg::ONE_Q16});
        end
    end

    assign o_sts.phase_ge_one = (r_phase >= lir_pkg::ONE_Q16);
    assign o_sts.out_busy     = r_out_valid;
    assign o_sts.out_taken    = out_taken;

    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_last_of_run = r_last;

    // A pending request that is not the last of its run leaves the phase below one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> r_phase < lir_pkg::ONE_Q16)
        else $error("run continues with phase at or above one");

    // The phase only moves on a load or at the end of an input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.load && !i_cmd.finish) |=> $stable(r_phase))
        else $error("phase changed without a command");

    // The last request of a run leaves the phase at or above one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> r_phase >= lir_pkg::ONE_Q16)
        else $error("run ended with phase below one");

endmodule
